### rtl/core/lcv_pkg.sv
// lcv_pkg: shared types and constants for the card number validator
// used by lcv_ctrl, lcv_datapath, luhn_card_validator and lcv_checker
package lcv_pkg;

   // decimal digits held after conversion, enough for a 64-bit value
   localparam int DIGITS  = 20;
   localparam int BCD_W   = DIGITS * 4;
   localparam int CNT_W   = 5;

   // verdict codes
   localparam logic [1:0] VERDICT_NONE  = 2'd0;
   localparam logic [1:0] VERDICT_BRAND1 = 2'd1;
   localparam logic [1:0] VERDICT_BRAND2 = 2'd2;
   localparam logic [1:0] VERDICT_BRAND3 = 2'd3;

   // brand rules
   localparam logic [3:0] LEAD_B1     = 4'd4;
   localparam logic [3:0] LEAD_B2_HI  = 4'd3;
   localparam logic [3:0] LEAD_B2_LOA = 4'd4;
   localparam logic [3:0] LEAD_B2_LOB = 4'd7;
   localparam logic [3:0] LEAD_B3_HI  = 4'd5;
   localparam logic [3:0] LEAD_B3_MIN = 4'd1;
   localparam logic [3:0] LEAD_B3_MAX = 4'd5;
   localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
   localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
   localparam logic [CNT_W-1:0] LEN_16 = 5'd16;

   typedef struct packed {
      logic load;
      logic convert;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_bit;
      logic scan_done;
   } stat_type;

endpackage

### rtl/core/lcv_ctrl.sv
// lcv_ctrl: sequencer for load, binary to decimal conversion, digit scan
// and result hand-off; depends on lcv_pkg for command and status structs
module lcv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  lcv_pkg::stat_type stat,
   output lcv_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_CONVERT = 2'd1;
   localparam logic [1:0] S_SCAN    = 2'd2;
   localparam logic [1:0] S_FINISH  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONVERT;
            end
         end
         S_CONVERT: begin
            cmd.convert = 1'b1;
            if (stat.last_bit) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/lcv_datapath.sv
// lcv_datapath: shift-add-3 binary to decimal converter, serial Luhn digit
// scan and result registers; depends on lcv_pkg
module lcv_datapath #(
   parameter int NUMBER_BITS = 64
) (
   input  logic                      clock,
   input  lcv_pkg::cmd_type          cmd,
   output lcv_pkg::stat_type         stat,
   input  logic [63:0]               card_number,
   output logic [1:0]                verdict,
   output logic                      checksum_ok,
   output logic [lcv_pkg::CNT_W-1:0] digit_count
);

   localparam int BitCntW = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

   logic [NUMBER_BITS-1:0]      bin_ff, bin_in;
   logic [lcv_pkg::BCD_W-1:0]   bcd_ff, bcd_in, bcd_adj;
   logic [BitCntW-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [lcv_pkg::CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic [3:0]                  acc_ff, acc_in;
   logic [lcv_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [3:0]                  hi_ff, hi_in, lo_ff, lo_in, prev_ff, prev_in;
   logic [1:0]                  verdict_ff, verdict_in;
   logic                        ok_ff, ok_in;
   logic [lcv_pkg::CNT_W-1:0]   dcount_ff, dcount_in;

   logic [3:0] dig;
   logic [4:0] term, sum;
   logic       sum_ok;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int j = 0; j < lcv_pkg::DIGITS; j++) begin
         if (bcd_ff[j*4 +: 4] >= 4'd5) bcd_adj[j*4 +: 4] = bcd_ff[j*4 +: 4] + 4'd3;
         else bcd_adj[j*4 +: 4] = bcd_ff[j*4 +: 4];
      end
   end

   // luhn term of the current digit, odd positions doubled with digit sum
   always_comb begin
      dig = bcd_ff[3:0];
      if (dig_cnt_ff[0]) begin
         if (dig < 4'd5) term = {dig, 1'b0};
         else term = {dig, 1'b0} - 5'd9;
      end else begin
         term = {1'b0, dig};
      end
      sum = {1'b0, acc_ff} + term;
   end

   assign stat.last_bit  = (bit_cnt_ff == BitCntW'(NUMBER_BITS - 1));
   assign stat.scan_done = (dig_cnt_ff == lcv_pkg::CNT_W'(lcv_pkg::DIGITS - 1));

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      prev_in    = prev_ff;
      priority if (cmd.load) begin
         bin_in     = card_number[NUMBER_BITS-1:0];
         bcd_in     = '0;
         bit_cnt_in = '0;
         dig_cnt_in = '0;
         acc_in     = '0;
         count_in   = lcv_pkg::CNT_W'(1);
         hi_in      = '0;
         lo_in      = '0;
         prev_in    = '0;
      end else if (cmd.convert) begin
         bcd_in     = {bcd_adj[lcv_pkg::BCD_W-2:0], bin_ff[NUMBER_BITS-1]};
         bin_in     = bin_ff << 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end else if (cmd.scan) begin
         acc_in = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
         if (dig != 4'd0) begin
            count_in = dig_cnt_ff + 1'b1;
            hi_in    = dig;
            lo_in    = prev_ff;
         end
         prev_in    = dig;
         bcd_in     = bcd_ff >> 4;
         dig_cnt_in = dig_cnt_ff + 1'b1;
      end else begin
         prev_in    = prev_ff;
      end
   end

   always_comb begin
      sum_ok     = (acc_ff == 4'd0);
      verdict_in = lcv_pkg::VERDICT_NONE;
      if (sum_ok) begin
         priority if (hi_ff == lcv_pkg::LEAD_B1 &&
                      (count_ff == lcv_pkg::LEN_13 || count_ff == lcv_pkg::LEN_16))
            verdict_in = lcv_pkg::VERDICT_BRAND1;
         else if (hi_ff == lcv_pkg::LEAD_B2_HI &&
                  (lo_ff == lcv_pkg::LEAD_B2_LOA || lo_ff == lcv_pkg::LEAD_B2_LOB) &&
                  count_ff == lcv_pkg::LEN_15)
            verdict_in = lcv_pkg::VERDICT_BRAND2;
         else if (hi_ff == lcv_pkg::LEAD_B3_HI && lo_ff >= lcv_pkg::LEAD_B3_MIN &&
                  lo_ff <= lcv_pkg::LEAD_B3_MAX && count_ff == lcv_pkg::LEN_16)
            verdict_in = lcv_pkg::VERDICT_BRAND3;
         else
            verdict_in = lcv_pkg::VERDICT_NONE;
      end
      if (cmd.finish) begin
         ok_in     = sum_ok;
         dcount_in = count_ff;
      end else begin
         ok_in      = ok_ff;
         dcount_in  = dcount_ff;
         verdict_in = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      acc_ff     <= acc_in;
      count_ff   <= count_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      prev_ff    <= prev_in;
      verdict_ff <= verdict_in;
      ok_ff      <= ok_in;
      dcount_ff  <= dcount_in;
   end

   assign verdict     = verdict_ff;
   assign checksum_ok = ok_ff;
   assign digit_count = dcount_ff;

endmodule

### rtl/core/luhn_card_validator.sv
// luhn_card_validator: top level, joins controller and datapath
// depends on lcv_pkg, lcv_ctrl and lcv_datapath
//
// Usage:
//   req channel: req_valid/req_ready with req_card_number, an unsigned
//   binary card number; only the low NUMBER_BITS bits are used.
//   rsp channel: rsp_valid/rsp_ready with rsp_verdict (0 none, 1..3 brand),
//   rsp_checksum_ok (luhn sum multiple of ten) and rsp_digit_count.
//   One result per transfer on req, in order.
// Timing:
//   req_ready is high only while the block is idle. After a transfer the
//   number is converted to 20 decimal digits, one input bit per cycle,
//   then the digits are scanned one per cycle and a finish step loads the
//   result. rsp_valid and req_ready rise together when the result is loaded,
//   so a new item is taken only after the last one is finished.
// Stall and reset:
//   a finished result waits in the output register; the next item is taken
//   meanwhile and holds in its last step until that register is free.
//   Reset clears the sequencer and rsp_valid; no results are pending after it.
module luhn_card_validator #(
   parameter int NUMBER_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [63:0]               req_card_number,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_verdict,
   output logic                      rsp_checksum_ok,
   output logic [lcv_pkg::CNT_W-1:0] rsp_digit_count
);

   lcv_pkg::cmd_type  cmd;
   lcv_pkg::stat_type stat;

   lcv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcv_datapath #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .stat        (stat),
      .card_number (req_card_number),
      .verdict     (rsp_verdict),
      .checksum_ok (rsp_checksum_ok),
      .digit_count (rsp_digit_count)
   );

endmodule

### rtl/core/lcv_checker.sv
// lcv_checker: port-level assertions for luhn_card_validator
// depends on lcv_pkg; bound to the top level at the end of this file
module lcv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_verdict,
   input logic                      rsp_checksum_ok,
   input logic [lcv_pkg::CNT_W-1:0] rsp_digit_count
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_brand_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != lcv_pkg::VERDICT_NONE |-> rsp_checksum_ok)
      else $error("brand reported with failed checksum");

   a_brand_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != lcv_pkg::VERDICT_NONE |->
      (rsp_digit_count == lcv_pkg::LEN_13 || rsp_digit_count == lcv_pkg::LEN_15 ||
       rsp_digit_count == lcv_pkg::LEN_16))
      else $error("brand reported with impossible length");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count != '0 &&
      rsp_digit_count <= lcv_pkg::CNT_W'(lcv_pkg::DIGITS))
      else $error("digit count out of range");

endmodule

bind luhn_card_validator lcv_checker u_lcv_checker (.*);
